FILE: design/pqsi_pkg.sv
// Package for the sorted priority queue: transaction types, field widths,
// command and status codes, and default sizes. Depends on nothing.
package pqsi_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int MAX_PRIORITY        = 5;

  localparam int VALUE_W  = 32;
  localparam int PRI_W    = 3;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                      command;
    logic signed [VALUE_W-1:0] value;
    logic [PRI_W-1:0]          priority_req;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] out_value;
    logic [PRI_W-1:0]          out_priority;
    logic [COUNT_W-1:0]        entry_count;
  } out_item_t;

  // One stored queue entry.
  typedef struct packed {
    logic [PRI_W-1:0]          priority_lvl;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

endpackage

FILE: design/priority_queue_sorted_insert.sv
// Sorted priority queue: a circular entry RAM walked by a small sequencer.
// Enqueue: a walk from the tail (S_SCAN) moves each entry of lower priority back one slot,
// with a further S_PLACE step when the walk reaches the head; the result leaves in S_FINISH.
// Dequeue reads the head (S_DQ_WAIT) before S_FINISH; full or empty rejections go straight
// to S_FINISH. The next transaction is taken only after the result is presented.
// Reset (rst_n low, synchronous) empties the queue; the entry RAM itself is not cleared.
module priority_queue_sorted_insert import pqsi_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(QUEUE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_PLACE   = 5'b00100,
    S_DQ_WAIT = 5'b01000,
    S_FINISH  = 5'b10000
  } state_t;

  // Physical slot of a logical position: the queue is a ring that starts at the head.
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] p);
    return (p == '0) ? LAST_ADDR : ADDR_W'(p - 1'b1);
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] p);
    return (p == LAST_ADDR) ? '0 : ADDR_W'(p + 1'b1);
  endfunction

  // A priority of zero is stored as one, and anything above the top level as the top level.
  function automatic logic [PRI_W-1:0] clamp_priority(input logic [PRI_W-1:0] raw);
    logic [PRI_W-1:0] p;
    p = raw;
    if (p == '0) begin
      p = PRI_W'(1);
    end
    if (int'(p) > MAX_PRIORITY) begin
      p = PRI_W'(MAX_PRIORITY);
    end
    return p;
  endfunction

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_W-1:0] left_r, left_nxt;
  entry_t            new_r, new_nxt;
  out_item_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  logic              in_acc;
  logic              q_full;
  logic              q_empty;
  logic [ADDR_W-1:0] occ_addr;
  logic [ADDR_W-1:0] tail_addr;
  logic [ADDR_W-1:0] slot_addr;
  logic [PRI_W-1:0]  in_pri;

  pqsi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // A new transaction is taken only while the sequencer is idle. The output register
  // decouples the result side, so a waiting result does not hold off the next input.
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);

  assign q_full    = (occ_r == DEPTH_CNT);
  assign q_empty   = (occ_r == '0);
  // Only used when the queue is not full, so the occupancy fits an address.
  assign occ_addr  = ADDR_W'(occ_r);
  assign tail_addr = wrap_add(head_r, ADDR_W'(occ_addr - 1'b1));
  assign slot_addr = wrap_add(head_r, occ_addr);
  assign in_pri    = clamp_priority(in_data.priority_req);

  // The enqueue walk starts at the tail and moves toward the head. Each cycle the entry
  // read in the previous cycle is compared with the new priority: if it is lower, the
  // entry moves back one slot and the next one up is read; otherwise the new entry lands
  // in the freed slot behind it. Equal priorities therefore keep arrival order.
  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    head_nxt      = head_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    left_nxt      = left_r;
    new_nxt       = new_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_ptr_r;
    ram_wdata     = ENTRY_W'(new_r);
    ram_raddr     = rd_ptr_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt.out_value = '0;
          if (in_data.command == CMD_ENQUEUE) begin
            if (q_full) begin
              res_nxt.status       = STATUS_FULL;
              res_nxt.out_priority = '0;
              res_nxt.entry_count  = COUNT_W'(occ_r);
              state_nxt            = S_FINISH;
            end else begin
              new_nxt.priority_lvl = in_pri;
              new_nxt.value        = in_data.value;
              occ_nxt              = CNT_W'(occ_r + 1'b1);
              res_nxt.status       = STATUS_DONE;
              res_nxt.out_priority = in_pri;
              res_nxt.entry_count  = COUNT_W'(occ_r + 1'b1);
              if (q_empty) begin
                // Nothing to walk past: the entry goes straight to the head slot.
                ram_we    = 1'b1;
                ram_waddr = slot_addr;
                ram_wdata = ENTRY_W'({in_pri, in_data.value});
                state_nxt = S_FINISH;
              end else begin
                ram_raddr  = tail_addr;
                rd_ptr_nxt = tail_addr;
                wr_ptr_nxt = slot_addr;
                left_nxt   = ADDR_W'(occ_addr - 1'b1);
                state_nxt  = S_SCAN;
              end
            end
          end else begin
            if (q_empty) begin
              res_nxt.status       = STATUS_EMPTY;
              res_nxt.out_priority = '0;
              res_nxt.entry_count  = '0;
              state_nxt            = S_FINISH;
            end else begin
              ram_raddr = head_r;
              head_nxt  = wrap_inc(head_r);
              occ_nxt   = CNT_W'(occ_r - 1'b1);
              state_nxt = S_DQ_WAIT;
            end
          end
        end
      end
      S_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = wr_ptr_r;
        if (rd_entry.priority_lvl < new_r.priority_lvl) begin
          ram_wdata  = ram_rdata;
          wr_ptr_nxt = rd_ptr_r;
          if (left_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            ram_raddr  = wrap_dec(rd_ptr_r);
            rd_ptr_nxt = wrap_dec(rd_ptr_r);
            left_nxt   = ADDR_W'(left_r - 1'b1);
          end
        end else begin
          ram_wdata = ENTRY_W'(new_r);
          state_nxt = S_FINISH;
        end
      end
      S_PLACE: begin
        // Every held entry had lower priority: the new one becomes the head.
        ram_we    = 1'b1;
        ram_waddr = wr_ptr_r;
        ram_wdata = ENTRY_W'(new_r);
        state_nxt = S_FINISH;
      end
      S_DQ_WAIT: begin
        res_nxt.status       = STATUS_DONE;
        res_nxt.out_value    = rd_entry.value;
        res_nxt.out_priority = rd_entry.priority_lvl;
        res_nxt.entry_count  = COUNT_W'(occ_r);
        state_nxt            = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    left_r     <= left_nxt;
    new_r      <= new_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The queue never holds more entries than it has slots.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_CNT)
    else $error("occupancy above queue depth");

  // A full rejection always reports a full queue.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_FULL) |->
      out_data.entry_count == COUNT_W'(QUEUE_DEPTH))
    else $error("full status with wrong entry count");

  // A dequeue from a non-empty queue removes exactly one entry.
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.command == CMD_DEQUEUE) && (occ_r != '0) |=>
      occ_r == CNT_W'($past(occ_r) - 1'b1))
    else $error("dequeue did not decrement occupancy");

endmodule

FILE: design/pqsi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the entry store of the priority queue.
module pqsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the sorted priority queue (priority_queue_sorted_insert).
// It uses the types and codes from pqsi_pkg and predicts every result with a queue model
// of its own.
`timescale 1ns / 1ps

module tb;
  import pqsi_pkg::*;

  localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
  // The limit lies far above the slowest legal run, so it leaves a wide margin.
  localparam int CYCLE_LIMIT = 400000;
  // The final wait is long enough for two enqueues that each shift the whole queue.
  localparam int TAIL_CYCLES = 40;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Model of the queue contents, head first, plus the results still owed by the block.
  entry_t    queue_model[$];
  out_item_t pending_results[$];

  int   error_count = 0;
  int   cycle_count = 0;
  // When set, neither side inserts idle cycles.
  logic idle_off    = 1'b0;

  priority_queue_sorted_insert #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The run gets a single reset, held low from time zero.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // A runaway run fails instead of hanging.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // The result side stalls about a third of the time unless idling is switched off.
  always @(posedge clk) begin
    out_stall <= idle_off ? 1'b0 : ($urandom_range(0, 99) < 32);
  end

  // Applies one transaction to the model and returns the result it should produce.
  // A requested priority outside 1..MAX_PRIORITY is clamped to the nearest end. The new
  // entry goes in front of the first entry with a strictly lower priority, so entries
  // of equal priority stay in arrival order.
  function automatic out_item_t predict_queue_op(in_item_t item);
    out_item_t        res;
    entry_t           ent;
    logic [PRI_W-1:0] pri;
    int               pos;
    res = '0;
    if (item.command == CMD_ENQUEUE) begin
      if (queue_model.size() >= QUEUE_DEPTH) begin
        // A full queue rejects the entry and leaves its contents as they are.
        res.status = STATUS_FULL;
      end else begin
        pri = item.priority_req;
        if (pri < 1) pri = PRI_W'(1);
        if (pri > PRI_W'(MAX_PRIORITY)) pri = PRI_W'(MAX_PRIORITY);
        pos = 0;
        while (pos < queue_model.size() && pri <= queue_model[pos].priority_lvl) pos++;
        ent.priority_lvl = pri;
        ent.value        = item.value;
        queue_model.insert(pos, ent);
        res.status       = STATUS_DONE;
        res.out_priority = pri;
      end
    end else begin
      if (queue_model.size() == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        ent              = queue_model.pop_front();
        res.status       = STATUS_DONE;
        res.out_value    = ent.value;
        res.out_priority = ent.priority_lvl;
      end
    end
    res.entry_count = COUNT_W'(queue_model.size());
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Monitor and checker. Every accepted input transaction is predicted here, and every
  // accepted result is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && in_valid && in_stall === 1'b0) begin
      pending_results.push_back(predict_queue_op(in_data));
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", out_data.status, want.status));
        if (out_data.out_value !== want.out_value)
          report_mismatch($sformatf("out_value %0d, wanted %0d",
                                    out_data.out_value, want.out_value));
        if (out_data.out_priority !== want.out_priority)
          report_mismatch($sformatf("out_priority %0d, wanted %0d",
                                    out_data.out_priority, want.out_priority));
        if (out_data.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, wanted %0d",
                                    out_data.entry_count, want.entry_count));
      end
    end
  end

  function automatic in_item_t make_item(logic cmd, logic signed [VALUE_W-1:0] val,
                                         logic [PRI_W-1:0] pri);
    in_item_t item;
    item.command      = cmd;
    item.value        = val;
    item.priority_req = pri;
    return item;
  endfunction

  // Mostly uniform values, with the signed extremes, zero and minus one mixed in.
  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // Sends one transaction. An idle gap, when one is drawn, is placed before the valid
  // goes up; valid stays high from one transaction into the next otherwise.
  task automatic send_item(in_item_t item);
    int gap;
    if (!idle_off && $urandom_range(0, 99) < 32) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      in_data  <= make_item(1'($urandom_range(0, 1)), $urandom(),
                            PRI_W'($urandom_range(0, 7)));
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Holds the sender off until the block has delivered every outstanding result.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_enqueue();
    send_item(make_item(CMD_ENQUEUE, rand_value(), PRI_W'($urandom_range(0, 7))));
  endtask

  task automatic send_random_dequeue();
    send_item(make_item(CMD_DEQUEUE, rand_value(), PRI_W'($urandom_range(0, 7))));
  endtask

  // Dequeue from the empty queue straight after reset.
  task automatic test_empty_dequeue();
    send_item(make_item(CMD_DEQUEUE, 32'sh7fff_ffff, 3'd7));
  endtask

  // Every raw priority code from 0 to 7 with extreme values, which exercises clamping at
  // both ends and ties in arrival order. The queue is then emptied and dequeued once more.
  task automatic test_priority_clamp_and_order();
    logic signed [VALUE_W-1:0] vals[8];
    vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1,
             32'sh5555_5555, 32'shaaaa_aaaa, 32'sd1, 32'sh0f0f_f0f0};
    for (int p = 0; p < 8; p++) send_item(make_item(CMD_ENQUEUE, vals[p], PRI_W'(p)));
    wait_for_results();
    repeat (9) send_item(make_item(CMD_DEQUEUE, 32'sd0, 3'd0));
  endtask

  // Fill the queue, push a few more that must be rejected, then drain it and underflow.
  task automatic test_fill_overflow_drain();
    int extra;
    for (int round = 0; round < 4; round++) begin
      extra = $urandom_range(1, 3);
      repeat (QUEUE_DEPTH + extra) send_random_enqueue();
      repeat (QUEUE_DEPTH + extra) send_random_dequeue();
    end
  endtask

  // Random mix in segments of fifty, each leaning toward filling, draining or neither.
  // One segment pair runs with no idling on either side.
  task automatic test_random_mix();
    int enq_pct;
    for (int seg = 0; seg < 10; seg++) begin
      case ($urandom_range(0, 2))
        0:       enq_pct = 25;
        1:       enq_pct = 50;
        default: enq_pct = 75;
      endcase
      idle_off = (seg == 4 || seg == 5);
      repeat (50) begin
        if ($urandom_range(0, 99) < enq_pct) send_random_enqueue();
        else send_random_dequeue();
      end
      if (seg == 6) wait_for_results();
    end
    idle_off = 1'b0;
  endtask

  initial begin
    @(posedge rst_n);
    repeat (2) @(posedge clk);
    test_empty_dequeue();
    test_priority_clamp_and_order();
    wait_for_results();
    test_fill_overflow_drain();
    test_random_mix();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
design/pqsi_pkg.sv
design/pqsi_ram.sv
design/priority_queue_sorted_insert.sv
tb/sv/tb.sv
